### design/idr_pkg.sv
// Shared types, constants and helpers for the interval deadline rearm block.
package idr_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int FIELD_W    = 32;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (TIME_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_IDX_W  = $clog2(DIV_STAGES);

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [FIELD_W-1:0]    field_t;
	typedef logic [2:0]            outcome_t;

	localparam logic OP_LENIENT = 1'b0;
	localparam logic OP_STRICT  = 1'b1;

	localparam outcome_t OUT_ON_TIME   = 3'd0;
	localparam outcome_t OUT_RESYNC    = 3'd1;
	localparam outcome_t OUT_RESTART   = 3'd2;
	localparam outcome_t OUT_SKIPPED   = 3'd3;
	localparam outcome_t OUT_ZERO_STEP = 3'd4;

	typedef struct packed {
		logic   opcode;
		field_t old_deadline;
		field_t step;
		field_t now;
	} req_t;

	typedef struct packed {
		field_t   new_deadline;
		outcome_t outcome;
		field_t   steps_missed;
	} res_t;

	// in-flight item: dq holds the dividend shifting out and quotient shifting in
	typedef struct packed {
		logic  opcode;
		time_t t;
		time_t step;
		time_t now_plus;
		time_t late;
		time_t rem;
		time_t dq;
	} work_t;

	function automatic time_t to_time(input field_t f);
		return TIME_WIDTH'(f);
	endfunction

	function automatic field_t to_field(input time_t x);
		return FIELD_W'(x);
	endfunction

endpackage

### design/idr_if.sv
// Request and result channel interfaces.
interface idr_req_if;
	import idr_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface idr_res_if;
	import idr_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/idr_prep.sv
// First stage: tentative deadline, lateness and now plus step.
module idr_prep (
	input  logic           clk,
	input  logic           arst_n,
	idr_req_if.sink        req,
	output idr_pkg::work_t pipe_s1,
	output logic           valid_s1,
	input  logic           dn_ready
);
	import idr_pkg::*;

	logic  en;
	time_t o;
	time_t s;
	time_t n;
	time_t t;

	assign en        = !valid_s1 || dn_ready;
	assign req.ready = en;

	assign o = to_time(req.data.old_deadline);
	assign s = to_time(req.data.step);
	assign n = to_time(req.data.now);
	assign t = o + s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s1.opcode   <= req.data.opcode;
			pipe_s1.t        <= t;
			pipe_s1.step     <= s;
			pipe_s1.now_plus <= n + s;
			pipe_s1.late     <= n - t;
			pipe_s1.rem      <= '0;
			pipe_s1.dq       <= n - t;
		end
	end

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request did not reach stage 1");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !dn_ready |=> valid_s1 && $stable(pipe_s1))
		else $error("stage 1 changed while stalled");

endmodule

### design/idr_div_stage.sv
// One divider stage: a few restoring division steps of lateness by step.
module idr_div_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [idr_pkg::DIV_IDX_W-1:0] idx,
	input  idr_pkg::work_t               up,
	input  logic                         up_valid,
	output logic                         up_ready,
	output idr_pkg::work_t               div_sk,
	output logic                         valid_sk,
	input  logic                         dn_ready
);
	import idr_pkg::*;

	logic              en;
	work_t             w;
	logic [TIME_WIDTH:0] trial;

	assign en       = !valid_sk || dn_ready;
	assign up_ready = en;

	always_comb begin
		w     = up;
		trial = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			if (int'(idx) * DIV_STEPS + i < TIME_WIDTH) begin
				trial = {w.rem, w.dq[TIME_WIDTH-1]};
				if (trial >= {1'b0, w.step}) begin
					w.rem = TIME_WIDTH'(trial - {1'b0, w.step});
					w.dq  = {w.dq[TIME_WIDTH-2:0], 1'b1};
				end else begin
					w.rem = TIME_WIDTH'(trial);
					w.dq  = {w.dq[TIME_WIDTH-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= 1'b0;
		end else if (en) begin
			valid_sk <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_sk <= w;
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sk && div_sk.step != '0 |-> div_sk.rem < div_sk.step)
		else $error("partial remainder not below divisor");

endmodule

### design/idr_final.sv
// Last stage: outcome select and result register.
module idr_final (
	input  logic           clk,
	input  logic           arst_n,
	input  idr_pkg::work_t up,
	input  logic           up_valid,
	output logic           up_ready,
	idr_res_if.source      res
);
	import idr_pkg::*;

	logic  en;
	logic  valid_q;
	res_t  out_q;
	res_t  r;
	logic  neg;
	logic  late_zero;

	assign en        = !valid_q || res.ready;
	assign up_ready  = en;
	assign res.valid = valid_q;
	assign res.data  = out_q;

	assign neg       = up.late[TIME_WIDTH-1];
	assign late_zero = (up.late == '0);

	always_comb begin
		r.new_deadline = to_field(up.t);
		r.outcome      = OUT_ON_TIME;
		r.steps_missed = '0;
		if (up.opcode == OP_LENIENT) begin
			if (!neg) begin
				if (up.late > up.step) begin
					r.new_deadline = to_field(up.now_plus);
					r.outcome      = OUT_RESTART;
				end else begin
					r.new_deadline = to_field(up.t + up.step);
					r.outcome      = OUT_RESYNC;
				end
			end
		end else begin
			if (!neg && !late_zero) begin
				if (up.step == '0) begin
					r.outcome = OUT_ZERO_STEP;
				end else begin
					// t + (q+1)*step == now - rem + step
					r.new_deadline = to_field(up.now_plus - up.rem);
					r.outcome      = OUT_SKIPPED;
					r.steps_missed = to_field(up.dq);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= r;
		end
	end

	a_missed_only_skip: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_q.outcome != OUT_SKIPPED |-> out_q.steps_missed == '0)
		else $error("steps_missed set outside skip outcome");

	a_last_fills: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && up_ready |=> valid_q)
		else $error("item lost entering result register");

endmodule

### design/interval_deadline_rearm.sv
// Top level of the interval deadline rearm block.
// Throughput: one request per cycle while the result side is ready; every stage has its own valid bit and ready.
// The divider is a pipelined restoring divider, four quotient bits per stage.
// Reset clears only the stage valid bits; the stage data registers are not reset.
module interval_deadline_rearm (
	input  logic      clk,
	input  logic      arst_n,
	idr_req_if.sink   req,
	idr_res_if.source res
);
	import idr_pkg::*;

	work_t stage_w [DIV_STAGES+1];
	logic  stage_v [DIV_STAGES+1];
	logic  stage_r [DIV_STAGES+1];

	idr_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.pipe_s1  (stage_w[0]),
		.valid_s1 (stage_v[0]),
		.dn_ready (stage_r[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		idr_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (DIV_IDX_W'(k)),
			.up       (stage_w[k]),
			.up_valid (stage_v[k]),
			.up_ready (stage_r[k]),
			.div_sk   (stage_w[k+1]),
			.valid_sk (stage_v[k+1]),
			.dn_ready (stage_r[k+1])
		);
	end

	idr_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.up       (stage_w[DIV_STAGES]),
		.up_valid (stage_v[DIV_STAGES]),
		.up_ready (stage_r[DIV_STAGES]),
		.res      (res)
	);

endmodule
